// File: rtl/core/artl_pkg.sv
// Shared types and codes for the address range table lookup core.
package artl_pkg;

    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_COMMIT = 2'd2;
    localparam logic [1:0] MODE_LOOKUP = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] address;
        logic [63:0] region_size;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic       dropped;
        logic [9:0] active_count;
    } res_t;

    // one table entry: half-open range [base, limit)
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] limit;
    } range_t;

endpackage

// File: rtl/core/address_range_table_lookup_core.sv
// Top level of the double-buffered address range table with binary-search lookup.
//
//  channel  | signals             | handshake
//  ---------+---------------------+-------------------------------------------
//  command  | start, busy, cmd    | item taken at clk edge with start & !busy
//  result   | done, result        | one-cycle strobe, receiver cannot stall
//
// Begin and append: result registered in the cycle after the item is taken.
// Lookup: each search step is an active RAM read then a compare, narrowing
//   the binary-search window until it empties or a range hits.
// Commit: insertion sort through the active RAM; each shadow entry is read
//   and latched, then larger active entries are read and shifted up one slot
//   until the entry is placed.
// Reset clears the counters, done and the sequencer only; RAM contents stay undefined.
// busy rises at the edge that takes a lookup or a non-empty commit and falls
//   at the edge that raises done.
module address_range_table_lookup_core #(
    parameter int MAX_RANGES = 512
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  artl_pkg::cmd_t  cmd,
    output logic            done,
    output artl_pkg::res_t  result
);
    import artl_pkg::*;

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CRD  = 3'd1;  // read shadow entry i
    localparam logic [2:0] ST_CLAT = 3'd2;  // latch shadow entry
    localparam logic [2:0] ST_CCMP = 3'd3;  // read active entry j-1, or place at slot 0
    localparam logic [2:0] ST_CSH  = 3'd4;  // shift or place
    localparam logic [2:0] ST_LRD  = 3'd5;  // read active entry mid
    localparam logic [2:0] ST_LCMP = 3'd6;  // compare and narrow

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] shadow_count_reg, shadow_count_next;
    logic [CW-1:0] active_reg, active_next;
    logic [CW-1:0] i_reg, i_next;      // commit source index
    logic [CW-1:0] j_reg, j_next;      // commit insertion slot
    logic [CW-1:0] lo_reg, lo_next;    // search window [lo, hi1)
    logic [CW-1:0] hi1_reg, hi1_next;
    logic [CW-1:0] mid_reg, mid_next;
    range_t        last_reg, last_next; // copy of last shadow entry
    range_t        cur_reg, cur_next;   // entry being inserted
    logic [63:0]   query_reg, query_next;
    logic          done_reg, done_next;
    res_t          res_reg, res_next;

    logic          sh_wr_en, sh_rd_en, ac_wr_en, ac_rd_en;
    logic [AW-1:0] sh_wr_addr, sh_rd_addr, ac_wr_addr, ac_rd_addr;
    range_t        sh_wr_data, ac_wr_data, sh_rd_data, ac_rd_data;

    logic [CW:0]   mid_sum;
    logic [CW+9:0] count_ext;

    artl_ram #(.DEPTH(MAX_RANGES)) u_shadow (
        .clk(clk), .wr_en(sh_wr_en), .wr_addr(sh_wr_addr), .wr_data(sh_wr_data),
        .rd_en(sh_rd_en), .rd_addr(sh_rd_addr), .rd_data(sh_rd_data)
    );

    artl_ram #(.DEPTH(MAX_RANGES)) u_active (
        .clk(clk), .wr_en(ac_wr_en), .wr_addr(ac_wr_addr), .wr_data(ac_wr_data),
        .rd_en(ac_rd_en), .rd_addr(ac_rd_addr), .rd_data(ac_rd_data)
    );

    // mid = (lo + hi) / 2 with hi = hi1 - 1; window is non-empty when used
    assign mid_sum = ({1'b0, lo_reg} + {1'b0, hi1_reg}) - {{CW{1'b0}}, 1'b1};

    always_comb
    begin
        state_next        = state_reg;
        shadow_count_next = shadow_count_reg;
        active_next       = active_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        lo_next           = lo_reg;
        hi1_next          = hi1_reg;
        mid_next          = mid_reg;
        last_next         = last_reg;
        cur_next          = cur_reg;
        query_next        = query_reg;
        done_next         = 1'b0;
        res_next          = res_reg;
        sh_wr_en          = 1'b0;
        sh_wr_addr        = shadow_count_reg[AW-1:0];
        sh_wr_data        = last_reg;
        sh_rd_en          = 1'b0;
        sh_rd_addr        = i_reg[AW-1:0];
        ac_wr_en          = 1'b0;
        ac_wr_addr        = j_reg[AW-1:0];
        ac_wr_data        = cur_reg;
        ac_rd_en          = 1'b0;
        ac_rd_addr        = mid_reg[AW-1:0];
        count_ext         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next.hit     = 1'b0;
                    res_next.dropped = 1'b0;
                    unique case (cmd.mode)
                        MODE_BEGIN:
                        begin
                            shadow_count_next = '0;
                            done_next         = 1'b1;
                        end
                        MODE_APPEND:
                        begin
                            done_next = 1'b1;
                            if (shadow_count_reg >= CW'(MAX_RANGES))
                            begin
                                res_next.dropped = 1'b1;
                            end
                            else if (shadow_count_reg != '0 && last_reg.limit == cmd.address)
                            begin
                                last_next.limit = cmd.address + cmd.region_size;
                                sh_wr_en        = 1'b1;
                                sh_wr_addr      = AW'(shadow_count_reg - CW'(1));
                                sh_wr_data      = last_next;
                            end
                            else
                            begin
                                last_next.base    = cmd.address;
                                last_next.limit   = cmd.address + cmd.region_size;
                                sh_wr_en          = 1'b1;
                                sh_wr_data        = last_next;
                                shadow_count_next = shadow_count_reg + CW'(1);
                            end
                        end
                        MODE_COMMIT:
                        begin
                            i_next = '0;
                            if (shadow_count_reg == '0)
                            begin
                                active_next = '0;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_CRD;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            query_next = cmd.address;
                            lo_next    = '0;
                            hi1_next   = active_reg;
                            state_next = ST_LRD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CRD:
            begin
                sh_rd_en   = 1'b1;
                state_next = ST_CLAT;
            end
            ST_CLAT:
            begin
                cur_next   = sh_rd_data;
                j_next     = i_reg;
                state_next = ST_CCMP;
            end
            ST_CCMP:
            begin
                if (j_reg == '0)
                begin
                    ac_wr_en = 1'b1;
                    i_next   = i_reg + CW'(1);
                    if (i_next == shadow_count_reg)
                    begin
                        active_next = shadow_count_reg;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CRD;
                    end
                end
                else
                begin
                    ac_rd_en   = 1'b1;
                    ac_rd_addr = AW'(j_reg - CW'(1));
                    state_next = ST_CSH;
                end
            end
            ST_CSH:
            begin
                ac_wr_en = 1'b1;
                if (ac_rd_data.base > cur_reg.base)
                begin
                    ac_wr_data = ac_rd_data;
                    j_next     = j_reg - CW'(1);
                    state_next = ST_CCMP;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    if (i_next == shadow_count_reg)
                    begin
                        active_next = shadow_count_reg;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CRD;
                    end
                end
            end
            ST_LRD:
            begin
                if (lo_reg < hi1_reg)
                begin
                    mid_next   = mid_sum[CW:1];
                    ac_rd_en   = 1'b1;
                    ac_rd_addr = mid_next[AW-1:0];
                    state_next = ST_LCMP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LCMP:
            begin
                priority if (query_reg < ac_rd_data.base)
                begin
                    hi1_next   = mid_reg;
                    state_next = ST_LRD;
                end
                else if (query_reg >= ac_rd_data.limit)
                begin
                    lo_next    = mid_reg + CW'(1);
                    state_next = ST_LRD;
                end
                else
                begin
                    res_next.hit = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        count_ext             = {10'd0, active_next};
        res_next.active_count = count_ext[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            shadow_count_reg <= '0;
            active_reg       <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            shadow_count_reg <= shadow_count_next;
            active_reg       <= active_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        lo_reg    <= lo_next;
        hi1_reg   <= hi1_next;
        mid_reg   <= mid_next;
        last_reg  <= last_next;
        cur_reg   <= cur_next;
        query_reg <= query_next;
        res_reg   <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: rtl/core/artl_ram.sv
// Synchronous single-write, single-read range memory with registered read data.
module artl_ram #(
    parameter int DEPTH = 512
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  artl_pkg::range_t             wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output artl_pkg::range_t             rd_data
);
    import artl_pkg::*;

    range_t mem [DEPTH];
    range_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/artl_checker.sv
// Port-level checks for the address range table lookup core, with bind.
module artl_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input artl_pkg::res_t  result
);
    import artl_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done)) else $error("item taken without effect");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done) else $error("busy ended without result");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.hit && result.dropped)) else $error("hit and dropped together");

endmodule

bind address_range_table_lookup_core artl_checker u_artl_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);
